### sv/dcq_pkg.sv
`timescale 1ns / 1ps

package dcq_pkg;

  // Q1.14 fixed point
  localparam int FRAC_BITS = 14;
  localparam int DATA_W    = 16;
  localparam int ONE       = 1 << FRAC_BITS;

  // trace sum and element differences
  localparam int SUM_W  = DATA_W + 2;
  localparam int DIFF_W = DATA_W + 1;
  localparam int MAG_W  = DATA_W;

  // first root: (1 + trace) << (FRAC_BITS - 2), padded to an even width
  localparam int RAD1_W  = 30;
  localparam int ROOT1_W = RAD1_W / 2;

  // divider: rounded (|d| << FRAC_BITS) over 4 * wr
  localparam int NUM_W = MAG_W + FRAC_BITS + 1;
  localparam int DEN_W = ROOT1_W + 2;
  localparam int LANES = 3;

  // norm root: sum of four squares, padded to an even width
  localparam int SQ_W    = 2 * DATA_W - 3;
  localparam int RAD2_W  = 32;
  localparam int ROOT2_W = RAD2_W / 2;

  // configuration register indexes
  localparam logic CFG_TRACE_THR = 1'b0;
  localparam logic CFG_NORM_TOL  = 1'b1;
  localparam int   CFG_IDX_W     = 1;
  localparam int   THR_W         = 15;
  localparam int   TOL_W         = 14;

  typedef logic signed [DATA_W-1:0] elem_t;

endpackage

### sv/dcq_if.sv
`timescale 1ns / 1ps

interface dcq_in_if import dcq_pkg::*; ();
  logic  valid;
  logic  ready;
  elem_t m00, m01, m02, m10, m11, m12, m20, m21, m22;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, output ready);
endinterface

interface dcq_out_if import dcq_pkg::*; ();
  logic  valid;
  logic  ready;
  elem_t quat_w, quat_x, quat_y, quat_z;
  logic  result_ok;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, result_ok, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, result_ok, output ready);
endinterface

### sv/dcq_isqrt.sv
`timescale 1ns / 1ps

// Pipelined integer square root, one root bit per stage, with side payload.
module dcq_isqrt import dcq_pkg::*; #(
  parameter int RAD_W  = RAD1_W,
  parameter int SIDE_W = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  logic [RAD_W-1:0]     rad_i,
  input  logic [SIDE_W-1:0]    side_i,
  output logic                 vld_o,
  output logic [RAD_W/2-1:0]   root_o,
  output logic [SIDE_W-1:0]    side_o
);

  localparam int N     = RAD_W / 2;
  localparam int REM_W = N + 2;

  logic [N:0]        vld;
  logic [RAD_W-1:0]  rad  [N+1];
  logic [REM_W-1:0]  rem  [N+1];
  logic [N-1:0]      root [N+1];
  logic [SIDE_W-1:0] side [N+1];

  assign vld[0]  = vld_i;
  assign rad[0]  = rad_i;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign side[0] = side_i;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [REM_W-1:0] cur, trial;
    logic             ge;

    // bring down two radicand bits, try root*4+1
    assign cur   = {rem[k][REM_W-3:0], rad[k][RAD_W-1 -: 2]};
    assign trial = {root[k], 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[k+1] <= 1'b0;
      end else if (en_i) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad[k+1]  <= rad[k] << 2;
        rem[k+1]  <= ge ? cur - trial : cur;
        root[k+1] <= {root[k][N-2:0], ge};
        side[k+1] <= side[k];
      end
    end
  end

  assign vld_o  = vld[N];
  assign root_o = root[N];
  assign side_o = side[N];

endmodule

### sv/dcq_div.sv
`timescale 1ns / 1ps

// Pipelined restoring divider, three lanes over a shared divisor, one bit per stage.
module dcq_div import dcq_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [NUM_W-1:0]  num_i [LANES],
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [NUM_W-1:0]  quo_o [LANES],
  output logic [SIDE_W-1:0] side_o
);

  logic [NUM_W:0]      vld;
  logic [DEN_W-1:0]    den  [NUM_W+1];
  logic [SIDE_W-1:0]   side [NUM_W+1];
  logic [NUM_W-1:0]    num  [NUM_W+1][LANES];
  logic [DEN_W-1:0]    rem  [NUM_W+1][LANES];
  logic [NUM_W-1:0]    quo  [NUM_W+1][LANES];

  assign vld[0]  = vld_i;
  assign den[0]  = den_i;
  assign side[0] = side_i;

  for (genvar l = 0; l < LANES; l++) begin : g_init
    assign num[0][l] = num_i[l];
    assign rem[0][l] = '0;
    assign quo[0][l] = '0;
    assign quo_o[l]  = quo[NUM_W][l];
  end

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[k+1] <= 1'b0;
      end else if (en_i) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den[k+1]  <= den[k];
        side[k+1] <= side[k];
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DEN_W:0] cur;
      logic           ge;

      // shift in next numerator bit, subtract when it fits
      assign cur = {rem[k][l], num[k][l][NUM_W-1]};
      assign ge  = cur >= {1'b0, den[k]};

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          num[k+1][l] <= num[k][l] << 1;
          rem[k+1][l] <= ge ? DEN_W'(cur - {1'b0, den[k]}) : cur[DEN_W-1:0];
          quo[k+1][l] <= {quo[k][l][NUM_W-2:0], ge};
        end
      end
    end
  end

  assign vld_o  = vld[NUM_W];
  assign side_o = side[NUM_W];

endmodule

### sv/dcq_ram_unused_placeholder_removed.sv
`timescale 1ns / 1ps

// Saturate a rounded quotient magnitude to one and apply its sign.
module dcq_sat import dcq_pkg::*; (
  input  logic             neg_i,
  input  logic [NUM_W-1:0] mag_i,
  output elem_t            val_o
);

  logic [DATA_W-1:0] lim;

  assign lim   = (mag_i > NUM_W'(ONE)) ? DATA_W'(ONE) : mag_i[DATA_W-1:0];
  assign val_o = neg_i ? -$signed(lim) : $signed(lim);

endmodule

### sv/dcm_to_quaternion.sv
`timescale 1ns / 1ps

// Channel | Dir | Payload                               | Handshake
// in_i    | in  | m00..m22, signed Q1.14                | valid/ready
// out_o   | out | quat_w..quat_z Q1.14, result_ok       | valid/ready
// cfg     | in  | cfg_idx_i, cfg_data_i                 | cfg_we_i
//
// One matrix per cycle unless the output stalls. Most of the latency
// comes from the two bit-per-stage square roots and the bit-per-stage
// divider. Reset clears all valid bits and thr_q and sets tol_q to 4.
// An output stall freezes every stage; nothing is lost or repeated.
module dcm_to_quaternion import dcq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  dcq_in_if.sink               in_i,
  dcq_out_if.source            out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [THR_W-1:0]     cfg_data_i
);

  logic [THR_W-1:0] thr_q;
  logic [TOL_W-1:0] tol_q;
  logic             en;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
      tol_q <= TOL_W'(4);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TRACE_THR: thr_q <= cfg_data_i;
        CFG_NORM_TOL:  tol_q <= cfg_data_i[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // whole pipe advances unless the output word is held
  assign en         = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  // stage 1: trace sum and differences
  logic                     s1_vld_q;
  logic signed [SUM_W-1:0]  s_q;
  logic signed [DIFF_W-1:0] d_q [LANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_q    <= SUM_W'(ONE) + SUM_W'(in_i.m00) + SUM_W'(in_i.m11) + SUM_W'(in_i.m22);
      d_q[0] <= DIFF_W'(in_i.m21) - DIFF_W'(in_i.m12);
      d_q[1] <= DIFF_W'(in_i.m02) - DIFF_W'(in_i.m20);
      d_q[2] <= DIFF_W'(in_i.m10) - DIFF_W'(in_i.m01);
    end
  end

  // trace test and first root
  localparam int SIDE1_W = 1 + LANES * (MAG_W + 1);

  logic               pass;
  logic [RAD1_W-1:0]  rad1;
  logic [SIDE1_W-1:0] side1_in, side1_out;
  logic [MAG_W-1:0]   mag [LANES];
  logic [LANES-1:0]   neg;

  assign pass = s_q > $signed({3'b000, thr_q});
  assign rad1 = {1'b0, s_q[SUM_W-2:0], (FRAC_BITS - 2)'(0)};

  for (genvar l = 0; l < LANES; l++) begin : g_mag
    logic signed [DIFF_W-1:0] ad;
    assign ad     = d_q[l][DIFF_W-1] ? -d_q[l] : d_q[l];
    assign mag[l] = ad[MAG_W-1:0];
    assign neg[l] = d_q[l][DIFF_W-1];
  end

  assign side1_in = {pass, neg, mag[0], mag[1], mag[2]};

  logic               r1_vld;
  logic [ROOT1_W-1:0] r1_root;

  dcq_isqrt #(.RAD_W(RAD1_W), .SIDE_W(SIDE1_W)) u_root1 (
    .clk_i, .rst_ni, .en_i(en),
    .vld_i(s1_vld_q), .rad_i(rad1), .side_i(side1_in),
    .vld_o(r1_vld), .root_o(r1_root), .side_o(side1_out)
  );

  // divider setup: numerator rounded by half the divisor
  localparam int SIDE2_W = 1 + LANES + ROOT1_W;

  logic               r1_pass;
  logic [LANES-1:0]   r1_neg;
  logic [MAG_W-1:0]   r1_mag [LANES];
  logic [ROOT1_W-1:0] wr;
  logic [DEN_W-1:0]   den;
  logic [NUM_W-1:0]   num [LANES];

  assign {r1_pass, r1_neg, r1_mag[0], r1_mag[1], r1_mag[2]} = side1_out;
  assign wr  = (r1_root == '0) ? ROOT1_W'(1) : r1_root;
  assign den = {wr, 2'b00};

  for (genvar l = 0; l < LANES; l++) begin : g_num
    assign num[l] = NUM_W'({r1_mag[l], FRAC_BITS'(0)}) + NUM_W'({wr, 1'b0});
  end

  logic               dv_vld;
  logic [NUM_W-1:0]   quo [LANES];
  logic [SIDE2_W-1:0] side2_out;
  logic               dv_pass;
  logic [LANES-1:0]   dv_neg;
  logic [ROOT1_W-1:0] dv_wr;

  dcq_div #(.SIDE_W(SIDE2_W)) u_div (
    .clk_i, .rst_ni, .en_i(en),
    .vld_i(r1_vld), .num_i(num), .den_i(den), .side_i({r1_pass, r1_neg, wr}),
    .vld_o(dv_vld), .quo_o(quo), .side_o(side2_out)
  );

  assign {dv_pass, dv_neg, dv_wr} = side2_out;

  // saturation and trace-fail zeroing
  elem_t sx, sy, sz, sw;

  dcq_sat u_sat_x (.neg_i(dv_neg[0]), .mag_i(quo[0]), .val_o(sx));
  dcq_sat u_sat_y (.neg_i(dv_neg[1]), .mag_i(quo[1]), .val_o(sy));
  dcq_sat u_sat_z (.neg_i(dv_neg[2]), .mag_i(quo[2]), .val_o(sz));

  assign sw = (dv_wr > ROOT1_W'(ONE)) ? DATA_W'(ONE) : $signed(DATA_W'(dv_wr));

  logic  sa_vld_q, sa_pass_q;
  elem_t qw_a_q, qx_a_q, qy_a_q, qz_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_vld_q <= 1'b0;
    end else if (en) begin
      sa_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sa_pass_q <= dv_pass;
      qw_a_q    <= dv_pass ? sw : '0;
      qx_a_q    <= dv_pass ? sx : '0;
      qy_a_q    <= dv_pass ? sy : '0;
      qz_a_q    <= dv_pass ? sz : '0;
    end
  end

  // squares
  logic  sb_vld_q, sb_pass_q;
  elem_t qw_b_q, qx_b_q, qy_b_q, qz_b_q;
  logic [SQ_W-1:0] ww_q, xx_q, yy_q, zz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_vld_q <= 1'b0;
    end else if (en) begin
      sb_vld_q <= sa_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_pass_q <= sa_pass_q;
      qw_b_q    <= qw_a_q;
      qx_b_q    <= qx_a_q;
      qy_b_q    <= qy_a_q;
      qz_b_q    <= qz_a_q;
      ww_q      <= SQ_W'(qw_a_q * qw_a_q);
      xx_q      <= SQ_W'(qx_a_q * qx_a_q);
      yy_q      <= SQ_W'(qy_a_q * qy_a_q);
      zz_q      <= SQ_W'(qz_a_q * qz_a_q);
    end
  end

  // norm root over the sum of squares
  localparam int SIDE3_W = 1 + 4 * DATA_W;

  logic [RAD2_W-1:0]  rad2;
  logic               r2_vld;
  logic [ROOT2_W-1:0] r2_root;
  logic [SIDE3_W-1:0] side3_out;
  logic               r2_pass;
  elem_t              r2_w, r2_x, r2_y, r2_z;

  assign rad2 = RAD2_W'(ww_q) + RAD2_W'(xx_q) + RAD2_W'(yy_q) + RAD2_W'(zz_q);

  dcq_isqrt #(.RAD_W(RAD2_W), .SIDE_W(SIDE3_W)) u_root2 (
    .clk_i, .rst_ni, .en_i(en),
    .vld_i(sb_vld_q), .rad_i(rad2),
    .side_i({sb_pass_q, qw_b_q, qx_b_q, qy_b_q, qz_b_q}),
    .vld_o(r2_vld), .root_o(r2_root), .side_o(side3_out)
  );

  assign {r2_pass, r2_w, r2_x, r2_y, r2_z} = side3_out;

  // norm deviation check
  logic [ROOT2_W-1:0] dev;

  assign dev = (r2_root >= ROOT2_W'(ONE)) ? r2_root - ROOT2_W'(ONE)
                                          : ROOT2_W'(ONE) - r2_root;

  // output register
  logic  out_vld_q, ok_q;
  elem_t ow_q, ox_q, oy_q, oz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= r2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ow_q <= r2_w;
      ox_q <= r2_x;
      oy_q <= r2_y;
      oz_q <= r2_z;
      ok_q <= r2_pass && (dev <= ROOT2_W'(tol_q));
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.quat_w    = ow_q;
  assign out_o.quat_x    = ox_q;
  assign out_o.quat_y    = oy_q;
  assign out_o.quat_z    = oz_q;
  assign out_o.result_ok = ok_q;

endmodule

### sv/dcq_checker.sv
`timescale 1ns / 1ps

module dcq_assert import dcq_pkg::*; (
  input logic  clk_i,
  input logic  rst_ni,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input elem_t quat_w,
  input elem_t quat_x,
  input elem_t quat_y,
  input elem_t quat_z,
  input logic  result_ok
);

  // a held output word stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  // input back-pressure only comes from a stalled output word
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output stall");

  // a good result has a nonzero scalar part
  a_ok_w: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && result_ok |-> quat_w != 16'sd0)
    else $error("result_ok with zero scalar part");

  // failed trace test gives an all-zero quaternion
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && quat_w == 16'sd0 |-> quat_x == 16'sd0 && quat_y == 16'sd0
                                      && quat_z == 16'sd0)
    else $error("partial quaternion on trace failure");

endmodule

bind dcm_to_quaternion dcq_assert u_dcq_assert (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .quat_w    (out_o.quat_w),
  .quat_x    (out_o.quat_x),
  .quat_y    (out_o.quat_y),
  .quat_z    (out_o.quat_z),
  .result_ok (out_o.result_ok)
);
